// ===== hdl/frame_history_exactness_tracker_core_assert.svh =====
// Assertion macros for the tracker RTL, used by fhet_ctrl.
`ifndef FRAME_HISTORY_EXACTNESS_TRACKER_CORE_ASSERT_SVH
`define FRAME_HISTORY_EXACTNESS_TRACKER_CORE_ASSERT_SVH

// Same-cycle implication, clocked on clk_i, off during reset.
`define FHET_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("fhet assertion failed");

// Next-cycle implication, clocked on clk_i, off during reset.
`define FHET_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("fhet assertion failed");

`endif

// ===== hdl/fhet_pkg.sv =====
`default_nettype none
package fhet_pkg;

  localparam int unsigned RING_SLOTS  = 8;
  localparam int unsigned SLOT_W      = $clog2(RING_SLOTS);
  localparam int unsigned MAX_ROWS    = 64;
  localparam int unsigned MAX_COLS    = 64;
  localparam int unsigned MAX_BANDS   = 16;
  localparam int unsigned REF_TRIES   = 3;

  localparam int unsigned FRAME_W     = 16;
  localparam int unsigned ROW_W       = 6;
  localparam int unsigned COL_W       = 6;
  localparam int unsigned BAND_W      = 4;
  localparam int unsigned STATUS_W    = 2;
  localparam int unsigned REFD_W      = 2;
  localparam int unsigned AGE_W       = 4;
  localparam int unsigned ROWS_REG_W  = 7;
  localparam int unsigned BANDS_REG_W = 5;
  localparam int unsigned CFG_IDX_W   = 2;
  localparam int unsigned CFG_DATA_W  = 7;

  // Exactness window: a chain of ring frames grows the neighborhood by one tile per frame.
  localparam int unsigned HALF        = RING_SLOTS;
  localparam int unsigned WIN         = 2 * HALF + 1;
  localparam int unsigned LEVELS      = 2 * RING_SLOTS - 1;
  localparam int unsigned LVL_W       = $clog2(LEVELS);
  localparam int unsigned ROW_CNT_W   = $clog2(WIN);
  localparam int unsigned WW          = ROW_W + 2;

  // Tile memory: one word per tile row of one slot.
  localparam int unsigned WORD_W      = STATUS_W * MAX_COLS;
  localparam int unsigned ADDR_W      = SLOT_W + ROW_W;
  localparam int unsigned MEM_DEPTH   = RING_SLOTS * MAX_ROWS;

  typedef enum logic [1:0] {
    OP_BEGIN  = 2'd0,
    OP_REPORT = 2'd1,
    OP_BAND   = 2'd2,
    OP_QUERY  = 2'd3
  } fhet_op_e;

  localparam logic [STATUS_W-1:0] ST_UNKNOWN   = 2'd0;
  localparam logic [STATUS_W-1:0] ST_RECEIVED  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_CONCEALED = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_ROWS  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COLS  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BANDS = 2'd2;

  typedef struct packed {
    logic                 accept;
    logic                 clr_all;
    logic                 clr_slot;
    logic                 band_set;
    logic                 rpt_rd;
    logic                 rpt_wr;
    logic                 use_level;
    logic                 q_rd;
    logic                 q_calc;
    logic                 q_skip;
    logic                 q_end;
    logic                 out_load;
    logic [ADDR_W-1:0]    clr_addr;
    logic [LVL_W-1:0]     level;
    logic [ROW_CNT_W-1:0] row;
  } fhet_cmd_t;

  typedef struct packed {
    logic lvl_present;
  } fhet_stat_t;

endpackage
`default_nettype wire

// ===== hdl/fhet_if.sv =====
`default_nettype none
interface fhet_in_if import fhet_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [1:0]         opcode;
  logic [FRAME_W-1:0] frame_number;
  logic [ROW_W-1:0]   tile_row;
  logic [COL_W-1:0]   tile_col;
  logic [BAND_W-1:0]  band_number;
  logic               got_tile;

  modport source (output valid, opcode, frame_number, tile_row, tile_col, band_number,
                  got_tile, input ready);
  modport sink (input valid, opcode, frame_number, tile_row, tile_col, band_number,
                got_tile, output ready);
endinterface

interface fhet_out_if import fhet_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] tile_status;
  logic                tile_exact;
  logic                band_seen;
  logic [REFD_W-1:0]   ref_distance;
  logic [AGE_W-1:0]    stale_age;

  modport source (output valid, tile_status, tile_exact, band_seen, ref_distance, stale_age,
                  input ready);
  modport sink (input valid, tile_status, tile_exact, band_seen, ref_distance, stale_age,
                output ready);
endinterface

interface fhet_cfg_if import fhet_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  reg_index;
  logic [CFG_DATA_W-1:0] reg_data;

  modport source (output valid, reg_index, reg_data, input ready);
  modport sink (input valid, reg_index, reg_data, output ready);
endinterface
`default_nettype wire

// ===== hdl/fhet_ctrl.sv =====
`default_nettype none
`include "frame_history_exactness_tracker_core_assert.svh"
module fhet_ctrl import fhet_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  input  wire fhet_op_e   in_op_i,
  output logic            in_ready_o,
  input  wire logic       out_ready_i,
  output logic            out_valid_o,
  input  wire fhet_stat_t stat_i,
  output fhet_cmd_t       cmd_o
);

  localparam logic [3:0] S_INIT   = 4'd0;
  localparam logic [3:0] S_IDLE   = 4'd1;
  localparam logic [3:0] S_CLR    = 4'd2;
  localparam logic [3:0] S_BAND   = 4'd3;
  localparam logic [3:0] S_RPT_RD = 4'd4;
  localparam logic [3:0] S_RPT_WR = 4'd5;
  localparam logic [3:0] S_Q_LVL  = 4'd6;
  localparam logic [3:0] S_Q_RD   = 4'd7;
  localparam logic [3:0] S_Q_CALC = 4'd8;
  localparam logic [3:0] S_Q_END  = 4'd9;
  localparam logic [3:0] S_OUT    = 4'd10;

  logic [3:0]           state_q, state_d;
  logic [ADDR_W-1:0]    cnt_q, cnt_d;
  logic [LVL_W-1:0]     level_q, level_d;
  logic [ROW_CNT_W-1:0] row_q, row_d;
  logic                 out_valid_q, out_valid_d;
  logic                 accept;
  logic                 q_accept;

  assign in_ready_o  = (state_q == S_IDLE);
  assign accept      = in_valid_i && (state_q == S_IDLE);
  assign q_accept    = accept && (in_op_i == OP_QUERY);
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    level_d = level_q;
    row_d   = row_q;
    cmd_o   = '0;
    cmd_o.accept   = accept;
    cmd_o.clr_addr = cnt_q;
    cmd_o.level    = level_q;
    cmd_o.row      = row_q;
    case (state_q)
      S_INIT: begin
        cmd_o.clr_all = 1'b1;
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == ADDR_W'(MEM_DEPTH - 1)) begin
          cnt_d   = '0;
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          case (in_op_i)
            OP_BEGIN: begin
              cnt_d   = '0;
              state_d = S_CLR;
            end
            OP_REPORT: state_d = S_RPT_RD;
            OP_BAND:   state_d = S_BAND;
            OP_QUERY: begin
              level_d = LVL_W'(LEVELS - 1);
              state_d = S_Q_LVL;
            end
            default: state_d = S_IDLE;
          endcase
        end
      end
      S_CLR: begin
        cmd_o.clr_slot = 1'b1;
        cnt_d = cnt_q + 1'b1;
        if (cnt_q[ROW_W-1:0] == ROW_W'(MAX_ROWS - 1)) begin
          cnt_d   = '0;
          state_d = S_IDLE;
        end
      end
      S_BAND: begin
        cmd_o.band_set = 1'b1;
        state_d = S_IDLE;
      end
      S_RPT_RD: begin
        cmd_o.rpt_rd = 1'b1;
        state_d = S_RPT_WR;
      end
      S_RPT_WR: begin
        cmd_o.rpt_wr = 1'b1;
        state_d = S_IDLE;
      end
      S_Q_LVL: begin
        cmd_o.use_level = 1'b1;
        if (stat_i.lvl_present) begin
          row_d   = '0;
          state_d = S_Q_RD;
        end else begin
          cmd_o.q_skip = 1'b1;
          if (level_q == '0) state_d = S_OUT;
          else level_d = level_q - 1'b1;
        end
      end
      S_Q_RD: begin
        cmd_o.q_rd = 1'b1;
        state_d = S_Q_CALC;
      end
      S_Q_CALC: begin
        cmd_o.q_calc = 1'b1;
        if (row_q == ROW_CNT_W'(WIN - 1)) begin
          state_d = S_Q_END;
        end else begin
          row_d   = row_q + 1'b1;
          state_d = S_Q_RD;
        end
      end
      S_Q_END: begin
        cmd_o.q_end = 1'b1;
        if (level_q == '0) begin
          state_d = S_OUT;
        end else begin
          level_d = level_q - 1'b1;
          state_d = S_Q_LVL;
        end
      end
      S_OUT: begin
        // hold until the output register is free
        if (!out_valid_q || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
    out_valid_d = (out_valid_q && !out_ready_i) || cmd_o.out_load;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_INIT;
      cnt_q       <= '0;
      level_q     <= '0;
      row_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      level_q     <= level_d;
      row_q       <= row_d;
      out_valid_q <= out_valid_d;
    end
  end

  `FHET_ASSERT_IMP(a_load_free, cmd_o.out_load, !out_valid_q || out_ready_i)
  `FHET_ASSERT_NXT(a_query_start, q_accept, state_q == S_Q_LVL && level_q == LVL_W'(LEVELS - 1))
  `FHET_ASSERT_IMP(a_calc_row, state_q == S_Q_CALC, row_q <= ROW_CNT_W'(WIN - 1))

endmodule
`default_nettype wire

// ===== hdl/fhet_dp.sv =====
`default_nettype none
module fhet_dp import fhet_pkg::*; (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire fhet_cmd_t             cmd_i,
  output fhet_stat_t                 stat_o,
  input  wire logic [1:0]            in_op_i,
  input  wire logic [FRAME_W-1:0]    in_frame_i,
  input  wire logic [ROW_W-1:0]      in_row_i,
  input  wire logic [COL_W-1:0]      in_col_i,
  input  wire logic [BAND_W-1:0]     in_band_i,
  input  wire logic                  in_got_i,
  input  wire logic                  cfg_valid_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i,
  output logic [STATUS_W-1:0]        tile_status_o,
  output logic                       tile_exact_o,
  output logic                       band_seen_o,
  output logic [REFD_W-1:0]          ref_distance_o,
  output logic [AGE_W-1:0]           stale_age_o
);

  logic [ROWS_REG_W-1:0]  rows_q, cols_q, eff_rows, eff_cols;
  logic [BANDS_REG_W-1:0] bands_q, eff_bands;

  logic                   slot_valid_q [RING_SLOTS];
  logic [FRAME_W-1:0]     slot_id_q    [RING_SLOTS];
  logic [MAX_BANDS-1:0]   band_q       [RING_SLOTS];

  logic [FRAME_W-1:0]     f_q;
  logic [ROW_W-1:0]       r_q;
  logic [COL_W-1:0]       c_q;
  logic [BAND_W-1:0]      b_q;
  logic                   got_q;

  logic                   prevp_q;
  logic [AGE_W-1:0]       age_q;
  logic [REFD_W-1:0]      refd_q;
  logic                   exact_q;
  logic [STATUS_W-1:0]    status_q;
  logic [WIN-1:0]         pw_q [WIN+2];
  logic [WIN-1:0]         cw_q [WIN];

  logic [WORD_W-1:0]      mem_q [MEM_DEPTH];
  logic [WORD_W-1:0]      rdata_q;
  logic                   mem_we, mem_re;
  logic [ADDR_W-1:0]      mem_addr;
  logic [WORD_W-1:0]      mem_wdata;

  logic [SLOT_W-1:0]      in_slot, lat_slot, sel_slot;
  logic [FRAME_W-1:0]     lvl_frame, sel_frame;
  logic                   sel_present, lat_inb, band_ok, rpt_ok, hood_c;
  logic [STATUS_W-1:0]    cur_st, new_st;
  logic [WW-1:0]          win_row_u;
  logic                   row_ok;
  logic [WW-1:0]          col_u [WIN];
  logic [WIN-1:0]         col_ok_v, hood_v, new_row;
  logic [STATUS_W-1:0]    st_v [WIN];

  assign eff_rows  = (rows_q > ROWS_REG_W'(MAX_ROWS)) ? ROWS_REG_W'(MAX_ROWS) : rows_q;
  assign eff_cols  = (cols_q > ROWS_REG_W'(MAX_COLS)) ? ROWS_REG_W'(MAX_COLS) : cols_q;
  assign eff_bands = (bands_q > BANDS_REG_W'(MAX_BANDS)) ? BANDS_REG_W'(MAX_BANDS) : bands_q;

  assign in_slot   = in_frame_i[SLOT_W-1:0];
  assign lat_slot  = f_q[SLOT_W-1:0];
  assign lvl_frame = f_q - FRAME_W'(cmd_i.level);
  assign sel_frame = cmd_i.use_level ? lvl_frame : f_q;
  assign sel_slot  = sel_frame[SLOT_W-1:0];
  assign sel_present = slot_valid_q[sel_slot] && (slot_id_q[sel_slot] == sel_frame);
  assign stat_o.lvl_present = sel_present;

  assign lat_inb = ({1'b0, r_q} < eff_rows) && ({1'b0, c_q} < eff_cols);
  assign band_ok = ({1'b0, b_q} < eff_bands);
  assign rpt_ok  = sel_present && lat_inb;

  assign cur_st = rdata_q[{c_q, 1'b0} +: STATUS_W];
  assign new_st = (got_q || cur_st == ST_RECEIVED) ? ST_RECEIVED : ST_CONCEALED;

  assign win_row_u = {2'b00, r_q} + WW'(cmd_i.row) - WW'(HALF);
  assign row_ok    = !win_row_u[WW-1] && (win_row_u[WW-2:0] < eff_rows);

  assign hood_c = (&cw_q[HALF-1][HALF+1:HALF-1]) && (&cw_q[HALF][HALF+1:HALF-1]) &&
                  (&cw_q[HALF+1][HALF+1:HALF-1]);

  // one window row: a cell is exact if outside the frame, received, or concealed over an exact hood one frame back
  always_comb begin
    for (int j = 0; j < WIN; j++) begin
      col_u[j]    = {2'b00, c_q} + WW'(j) - WW'(HALF);
      col_ok_v[j] = !col_u[j][WW-1] && (col_u[j][WW-2:0] < eff_cols);
      st_v[j]     = rdata_q[{col_u[j][COL_W-1:0], 1'b0} +: STATUS_W];
      hood_v[j]   = 1'b1;
      for (int a = 0; a < 3; a++) begin
        for (int b = -1; b <= 1; b++) begin
          if (j + b >= 0 && j + b < WIN) hood_v[j] = hood_v[j] & pw_q[a][j+b];
        end
      end
      new_row[j] = !(row_ok && col_ok_v[j]) || (st_v[j] == ST_RECEIVED) ||
                   ((st_v[j] == ST_CONCEALED) && prevp_q && hood_v[j]);
    end
  end

  always_comb begin
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    mem_addr  = {lat_slot, r_q};
    mem_wdata = rdata_q;
    if (cmd_i.clr_all) begin
      mem_we    = 1'b1;
      mem_addr  = cmd_i.clr_addr;
      mem_wdata = '0;
    end else if (cmd_i.clr_slot) begin
      mem_we    = 1'b1;
      mem_addr  = {lat_slot, cmd_i.clr_addr[ROW_W-1:0]};
      mem_wdata = '0;
    end else if (cmd_i.rpt_rd) begin
      mem_re = 1'b1;
    end else if (cmd_i.rpt_wr) begin
      mem_we = rpt_ok;
      mem_wdata[{c_q, 1'b0} +: STATUS_W] = new_st;
    end else if (cmd_i.q_rd) begin
      mem_re   = 1'b1;
      mem_addr = {lvl_frame[SLOT_W-1:0], win_row_u[ROW_W-1:0]};
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) mem_q[mem_addr] <= mem_wdata;
    else if (mem_re) rdata_q <= mem_q[mem_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_q  <= ROWS_REG_W'(MAX_ROWS);
      cols_q  <= ROWS_REG_W'(MAX_COLS);
      bands_q <= BANDS_REG_W'(MAX_BANDS);
      for (int s = 0; s < RING_SLOTS; s++) begin
        slot_valid_q[s] <= 1'b0;
        slot_id_q[s]    <= '0;
        band_q[s]       <= '0;
      end
    end else begin
      if (cfg_valid_i) begin
        case (cfg_idx_i)
          CFG_ROWS:  rows_q  <= cfg_data_i[ROWS_REG_W-1:0];
          CFG_COLS:  cols_q  <= cfg_data_i[ROWS_REG_W-1:0];
          CFG_BANDS: bands_q <= cfg_data_i[BANDS_REG_W-1:0];
          default: ;
        endcase
      end
      if (cmd_i.accept && in_op_i == OP_BEGIN) begin
        slot_valid_q[in_slot] <= 1'b1;
        slot_id_q[in_slot]    <= in_frame_i;
        band_q[in_slot]       <= '0;
      end
      if (cmd_i.band_set && sel_present && band_ok) band_q[lat_slot][b_q] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      f_q      <= in_frame_i;
      r_q      <= in_row_i;
      c_q      <= in_col_i;
      b_q      <= in_band_i;
      got_q    <= in_got_i;
      prevp_q  <= 1'b0;
      age_q    <= AGE_W'(RING_SLOTS);
      refd_q   <= REFD_W'(REF_TRIES);
      exact_q  <= 1'b0;
      status_q <= ST_UNKNOWN;
    end
    if (cmd_i.q_skip) prevp_q <= 1'b0;
    if (cmd_i.q_calc) begin
      // advance both windows by one row
      for (int k = 0; k < WIN - 1; k++) cw_q[k] <= cw_q[k+1];
      cw_q[WIN-1] <= new_row;
      for (int k = 0; k < WIN + 1; k++) pw_q[k] <= pw_q[k+1];
      pw_q[WIN+1] <= '1;
      if (cmd_i.level == '0 && cmd_i.row == ROW_CNT_W'(HALF)) status_q <= cur_st;
    end
    if (cmd_i.q_end) begin
      pw_q[0] <= '1;
      for (int k = 0; k < WIN; k++) pw_q[k+1] <= cw_q[k];
      pw_q[WIN+1] <= '1;
      prevp_q <= 1'b1;
      if (cmd_i.level == '0) exact_q <= cw_q[HALF][HALF];
      if (cmd_i.level < LVL_W'(RING_SLOTS) && cw_q[HALF][HALF]) age_q <= AGE_W'(cmd_i.level);
      if (cmd_i.level >= LVL_W'(1) && cmd_i.level <= LVL_W'(REF_TRIES) && hood_c) begin
        refd_q <= REFD_W'(cmd_i.level - 1'b1);
      end
    end
    if (cmd_i.out_load) begin
      tile_status_o  <= lat_inb ? status_q : ST_UNKNOWN;
      tile_exact_o   <= lat_inb && exact_q;
      band_seen_o    <= sel_present && band_ok && band_q[lat_slot][b_q];
      ref_distance_o <= lat_inb ? refd_q : REFD_W'(REF_TRIES);
      stale_age_o    <= lat_inb ? age_q : AGE_W'(RING_SLOTS);
    end
  end

endmodule
`default_nettype wire

// ===== hdl/frame_history_exactness_tracker_core.sv =====
// Begin frame: accept, then clear the slot's 64 tile rows one by one.
// Tile report: accept, row read, row write. Band done: accept, then set the flag.
// Query: scans the 15 frames back from the queried one; each ring frame found (at most 8)
// reads 17 tile rows through the single memory port.
// Reset: clears slots and flags at once, then sweeps all 512 tile rows; no item is
// accepted during the sweep. One item is worked on at a time.
`default_nettype none
module frame_history_exactness_tracker_core import fhet_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  fhet_in_if.sink   in_i,
  fhet_out_if.source out_o,
  fhet_cfg_if.sink  cfg_i
);

  fhet_cmd_t  cmd;
  fhet_stat_t stat;

  assign cfg_i.ready = 1'b1;

  fhet_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_op_i     (fhet_op_e'(in_i.opcode)),
    .in_ready_o  (in_i.ready),
    .out_ready_i (out_o.ready),
    .out_valid_o (out_o.valid),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  fhet_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .stat_o         (stat),
    .in_op_i        (in_i.opcode),
    .in_frame_i     (in_i.frame_number),
    .in_row_i       (in_i.tile_row),
    .in_col_i       (in_i.tile_col),
    .in_band_i      (in_i.band_number),
    .in_got_i       (in_i.got_tile),
    .cfg_valid_i    (cfg_i.valid),
    .cfg_idx_i      (cfg_i.reg_index),
    .cfg_data_i     (cfg_i.reg_data),
    .tile_status_o  (out_o.tile_status),
    .tile_exact_o   (out_o.tile_exact),
    .band_seen_o    (out_o.band_seen),
    .ref_distance_o (out_o.ref_distance),
    .stale_age_o    (out_o.stale_age)
  );

endmodule
`default_nettype wire

// ===== bench/frame_history_exactness_tracker_core_tb.sv =====
`default_nettype none
module frame_history_exactness_tracker_core_tb;
  import fhet_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic                exact;
    logic                seen;
    logic [REFD_W-1:0]   refd;
    logic [AGE_W-1:0]    age;
  } tile_answer_t;

  class exactness_scoreboard;
    bit [1:0]  tiles   [RING_SLOTS][MAX_ROWS*MAX_COLS];
    bit        exmap   [RING_SLOTS][MAX_ROWS*MAX_COLS];
    bit        built   [RING_SLOTS];
    bit        live    [RING_SLOTS];
    bit [15:0] fid     [RING_SLOTS];
    bit [15:0] bflags  [RING_SLOTS];
    int        rows_reg, cols_reg, bands_reg;
    tile_answer_t answers_due[$];
    int        mismatches;

    function new();
      rows_reg = 64; cols_reg = 64; bands_reg = 16; mismatches = 0;
      foreach (live[s]) begin
        live[s] = 0; fid[s] = 0; bflags[s] = 0;
      end
      foreach (tiles[s, i]) tiles[s][i] = ST_UNKNOWN;
    endfunction

    function int rows(); return rows_reg < MAX_ROWS ? rows_reg : MAX_ROWS; endfunction
    function int cols(); return cols_reg < MAX_COLS ? cols_reg : MAX_COLS; endfunction
    function int bands(); return bands_reg < MAX_BANDS ? bands_reg : MAX_BANDS; endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      if (idx == CFG_ROWS) rows_reg = val;
      else if (idx == CFG_COLS) cols_reg = val;
      else if (idx == CFG_BANDS) bands_reg = val[BANDS_REG_W-1:0];
    endfunction

    function int slot_of(bit [15:0] f);
      int s;
      s = f % RING_SLOTS;
      return (live[s] && fid[s] == f) ? s : -1;
    endfunction

    function bit hood_ok(int s, int row, int col);
      int r0, c0;
      if (s < 0) return 0;
      r0 = row > 0 ? row - 1 : 0;
      c0 = col > 0 ? col - 1 : 0;
      for (int r = r0; r <= row + 1 && r < rows(); r++)
        for (int c = c0; c <= col + 1 && c < cols(); c++)
          if (!exmap[s][r*MAX_COLS+c]) return 0;
      return 1;
    endfunction

    function void build(int s, int depth);
      int prev;
      bit [1:0] st;
      if (built[s] || depth > RING_SLOTS) return;
      prev = slot_of(fid[s] - 16'd1);
      if (prev >= 0 && prev != s) build(prev, depth + 1);
      else prev = -1;
      for (int r = 0; r < rows(); r++)
        for (int c = 0; c < cols(); c++) begin
          st = tiles[s][r*MAX_COLS+c];
          exmap[s][r*MAX_COLS+c] = (st == ST_RECEIVED) ||
            (st == ST_CONCEALED && prev >= 0 && built[prev] && hood_ok(prev, r, c));
        end
      built[s] = 1;
    endfunction

    function void note_item(fhet_op_e op, bit [15:0] f, int row, int col, int band, bit got);
      int s, idx, m;
      bit inb;
      tile_answer_t a;
      inb = row < rows() && col < cols();
      s = slot_of(f);
      idx = row * MAX_COLS + col;
      case (op)
        OP_BEGIN: begin
          s = f % RING_SLOTS;
          live[s] = 1; fid[s] = f; bflags[s] = 0;
          for (int i = 0; i < MAX_ROWS*MAX_COLS; i++) tiles[s][i] = ST_UNKNOWN;
        end
        OP_REPORT: begin
          if (s >= 0 && inb) begin
            if (got) tiles[s][idx] = ST_RECEIVED;
            else if (tiles[s][idx] != ST_RECEIVED) tiles[s][idx] = ST_CONCEALED;
          end
        end
        OP_BAND: begin
          if (s >= 0 && band < bands()) bflags[s][band] = 1'b1;
        end
        default: begin
          a = '0;
          a.refd = REF_TRIES;
          a.age = RING_SLOTS;
          if (s >= 0 && band < bands()) a.seen = bflags[s][band];
          if (inb) begin
            foreach (built[k]) built[k] = 0;
            foreach (live[k]) if (live[k]) build(k, 0);
            if (s >= 0) begin
              a.status = tiles[s][idx];
              a.exact = exmap[s][idx];
            end
            for (int d = 0; d < REF_TRIES; d++) begin
              m = slot_of(f - 16'(1 + d));
              if (m >= 0 && hood_ok(m, row, col)) begin
                a.refd = d;
                break;
              end
            end
            for (int d = 0; d < RING_SLOTS; d++) begin
              m = slot_of(f - 16'(d));
              if (m >= 0 && exmap[m][idx]) begin
                a.age = d;
                break;
              end
            end
          end
          answers_due.push_back(a);
        end
      endcase
    endfunction

    function void check_result(tile_answer_t got_a);
      tile_answer_t e;
      if (answers_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h", got_a);
        return;
      end
      e = answers_due.pop_front();
      if (e.status !== got_a.status || e.exact !== got_a.exact || e.seen !== got_a.seen ||
          e.refd !== got_a.refd || e.age !== got_a.age) begin
        mismatches++;
        if (mismatches <= 10)
          $display({"mismatch: expected st=%0d ex=%0d seen=%0d refd=%0d age=%0d, ",
                    "got st=%0d ex=%0d seen=%0d refd=%0d age=%0d"},
                   e.status, e.exact, e.seen, e.refd, e.age,
                   got_a.status, got_a.exact, got_a.seen, got_a.refd, got_a.age);
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  fhet_in_if  in_if();
  fhet_out_if out_if();
  fhet_cfg_if cfg_if();

  frame_history_exactness_tracker_core dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if),
    .out_o (out_if),
    .cfg_i (cfg_if)
  );

  exactness_scoreboard sb = new();
  int send_idle = 0;
  int recv_idle = 0;
  int hold_cnt = 0;
  int quiet_cycles = 0;
  bit [15:0] fcur;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  initial begin
    in_if.valid = 1'b0; in_if.opcode = OP_BEGIN; in_if.frame_number = '0;
    in_if.tile_row = '0; in_if.tile_col = '0; in_if.band_number = '0; in_if.got_tile = 1'b0;
    cfg_if.valid = 1'b0; cfg_if.reg_index = CFG_ROWS; cfg_if.reg_data = '0;
    out_if.ready = 1'b0;
  end

  // receiver ready; a hold-off count overrides the random idling
  always @(negedge clk_i) begin
    if (hold_cnt > 0) begin
      out_if.ready <= 1'b0;
      hold_cnt <= hold_cnt - 1;
    end else begin
      out_if.ready <= ($urandom_range(99) >= recv_idle);
    end
  end

  always @(posedge clk_i) begin
    if (out_if.valid && out_if.ready)
      sb.check_result({out_if.tile_status, out_if.tile_exact, out_if.band_seen,
                       out_if.ref_distance, out_if.stale_age});
  end

  always @(posedge clk_i) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
        (cfg_if.valid && cfg_if.ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= 20000) begin
      $display("[frame_history_exactness_tracker_core] ERROR");
      $finish;
    end
  end

  task automatic push_item(fhet_op_e op, bit [15:0] f, int row, int col, int band, bit got);
    @(negedge clk_i);
    while ($urandom_range(99) < send_idle) begin
      in_if.valid = 1'b0;
      @(negedge clk_i);
    end
    in_if.valid = 1'b1;
    in_if.opcode = op;
    in_if.frame_number = f;
    in_if.tile_row = row[ROW_W-1:0];
    in_if.tile_col = col[COL_W-1:0];
    in_if.band_number = band[BAND_W-1:0];
    in_if.got_tile = got;
    do @(posedge clk_i); while (!in_if.ready);
    sb.note_item(op, f, row, col, band, got);
  endtask

  task automatic drain_and_idle();
    @(negedge clk_i);
    in_if.valid = 1'b0;
    while (sb.answers_due.size() != 0) @(posedge clk_i);
    // a begin frame may still be clearing its slot
    repeat (400) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    @(negedge clk_i);
    cfg_if.valid = 1'b1;
    cfg_if.reg_index = idx;
    cfg_if.reg_data = val;
    do @(posedge clk_i); while (!cfg_if.ready);
    sb.set_reg(idx, val);
    @(negedge clk_i);
    cfg_if.valid = 1'b0;
  endtask

  function automatic int pick_coord(int lim);
    if (lim > 0 && $urandom_range(9) != 0) return $urandom_range(lim - 1);
    return $urandom_range(63);
  endfunction

  task automatic random_item();
    int kind, row, col, band;
    bit [15:0] f;
    kind = $urandom_range(99);
    f = fcur - 16'($urandom_range(9));
    row = pick_coord(sb.rows());
    col = pick_coord(sb.cols());
    band = pick_coord(sb.bands()) & 15;
    if (kind < 10) begin
      fcur = ($urandom_range(19) == 0) ? 16'($urandom) : fcur + 16'd1;
      push_item(OP_BEGIN, fcur, 0, 0, 0, 1'b0);
    end else if (kind < 55) begin
      push_item(OP_REPORT, f, row, col, band, ($urandom_range(99) < 65));
    end else if (kind < 63) begin
      push_item(OP_BAND, f, row, col, band, 1'b0);
    end else if (kind < 92) begin
      push_item(OP_QUERY, ($urandom_range(2) == 0) ? fcur : f, row, col, band, 1'b0);
    end else begin
      push_item(fhet_op_e'($urandom_range(3)), 16'($urandom), $urandom_range(63),
                $urandom_range(63), $urandom_range(15), 1'($urandom));
    end
  endtask

  int pr [7] = '{1, 2, 3, 0, 127, 5, 2};
  int pc [7] = '{1, 3, 3, 0, 127, 4, 2};
  int pb [7] = '{1, 4, 16, 0, 31, 7, 2};
  int pn [7] = '{200, 300, 300, 60, 40, 300, 250};

  initial begin
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed, reset geometry 64x64, 16 bands
    push_item(OP_QUERY, 16'd0, 0, 0, 0, 1'b0);
    push_item(OP_BEGIN, 16'd0, 0, 0, 0, 1'b0);
    push_item(OP_REPORT, 16'd0, 0, 0, 0, 1'b1);
    push_item(OP_REPORT, 16'd0, 63, 63, 0, 1'b0);
    push_item(OP_REPORT, 16'd0, 0, 0, 0, 1'b0);
    push_item(OP_BAND, 16'd0, 0, 0, 15, 1'b0);
    push_item(OP_BAND, 16'd8, 0, 0, 3, 1'b0);
    push_item(OP_REPORT, 16'd8, 1, 1, 0, 1'b1);
    push_item(OP_QUERY, 16'd0, 0, 0, 15, 1'b0);
    push_item(OP_QUERY, 16'd0, 63, 63, 15, 1'b0);
    push_item(OP_QUERY, 16'd5, 0, 0, 0, 1'b0);
    push_item(OP_BEGIN, 16'hFFFF, 0, 0, 0, 1'b0);
    push_item(OP_REPORT, 16'hFFFF, 63, 0, 9, 1'b1);
    push_item(OP_BEGIN, 16'd1, 0, 0, 0, 1'b0);
    push_item(OP_REPORT, 16'd1, 0, 0, 0, 1'b0);
    push_item(OP_QUERY, 16'd1, 0, 0, 0, 1'b0);
    push_item(OP_QUERY, 16'd1, 63, 0, 15, 1'b1);
    drain_and_idle();
    write_reg(CFG_SPARE, 7'h7F);

    fcur = 16'hFFF8;
    for (int p = 0; p < 7; p++) begin
      send_idle = (p < 2) ? 21 : (p < 4) ? 70 : 0;
      recv_idle = (p < 2) ? 70 : (p < 4) ? 21 : 0;
      write_reg(CFG_ROWS, CFG_DATA_W'(pr[p]));
      write_reg(CFG_COLS, CFG_DATA_W'(pc[p]));
      write_reg(CFG_BANDS, CFG_DATA_W'(pb[p]));
      if (p == 5) hold_cnt = 1500;
      for (int n = 0; n < pn[p]; n++) random_item();
      drain_and_idle();
    end

    if (sb.mismatches == 0 && sb.answers_due.size() == 0)
      $display("[frame_history_exactness_tracker_core] OK");
    else
      $display("[frame_history_exactness_tracker_core] ERROR");
    $finish;
  end
endmodule
`default_nettype wire
